@@ rtl/bra_pkg.sv @@
// Shared widths, types, reset values and register indexes for the rational approximation unit.
package bra_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int WIDE_WIDTH      = 2 * VALUE_WIDTH;
  localparam int COUNT_WIDTH     = $clog2(VALUE_WIDTH);
  localparam int CFG_INDEX_WIDTH = 1;

  typedef logic [VALUE_WIDTH-1:0]     value_t;
  typedef logic [WIDE_WIDTH-1:0]      wide_t;
  typedef logic [COUNT_WIDTH-1:0]     count_t;
  typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

  localparam value_t NUM_LIMIT_RESET = value_t'(16777215);
  localparam value_t DEN_LIMIT_RESET = value_t'(256);

  localparam cfg_index_t REG_NUM_LIMIT = cfg_index_t'(0);
  localparam cfg_index_t REG_DEN_LIMIT = cfg_index_t'(1);

endpackage

@@ rtl/best_rational_approximation_unit.sv @@
// Top level: best bounded rational approximation by continued-fraction expansion.
//
// Input channel (in_valid/in_ready) takes one fraction frac_numerator/frac_denominator
// per transaction; output channel (out_valid/out_ready) returns approx_numerator/
// approx_denominator, the closest fraction within the two configured limits.
// Limits are written through cfg_write/cfg_index/cfg_data; the user must write them
// only while the unit is idle, as the block itself does not enforce it.
// Each continued-fraction term takes one restoring division (the shared
// divider sets the pace) plus a shift-add multiply that stops once the term's
// remaining bits are zero. When a limit is crossed, up to two more divisions
// and up to two multiply passes follow. The longest expansion of a 32-bit
// input has about 47 terms. One transaction is worked at a time.
//
// The result sits in an output register, so in_ready returns as soon as the result
// is parked there, even if the receiver stalls; a further result waits in its final
// state until the register is free. Reset empties the output register, returns the
// sequencer to idle and restores the limits to 16777215 and 256.
module best_rational_approximation_unit
  import bra_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  value_t     frac_numerator,
  input  value_t     frac_denominator,
  output logic       out_valid,
  input  logic       out_ready,
  output value_t     approx_numerator,
  output value_t     approx_denominator,
  input  logic       cfg_write,
  input  cfg_index_t cfg_index,
  input  value_t     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,     // loop test: remainder zero ends the expansion
    S_DIV,       // waiting on num / den
    S_MUL,       // waiting on term * p_cur, term * q_cur; limit test
    S_RN,        // room on the numerator side
    S_RN_WAIT,
    S_RD,        // room on the denominator side
    S_RD_WAIT,
    S_PICK,      // semi-convergent vs previous convergent
    S_CMP,       // half-term tie break by cross products
    S_SEMI,      // build the semi-convergent
    S_EMIT
  } state_t;

  state_t state;

  value_t num_limit;
  value_t den_limit;

  // Euclid state
  value_t num;
  value_t den;
  value_t rem;
  value_t term;

  // convergents
  value_t p_old;
  value_t p_cur;
  value_t q_old;
  value_t q_cur;

  value_t room_n;
  value_t room_d;

  // shared arithmetic units
  logic   div_start;
  value_t div_dividend;
  value_t div_divisor;
  logic   div_busy;
  value_t div_quotient;
  value_t div_remainder;

  logic   mul_start;
  value_t mul_a_mcand;
  value_t mul_a_mplier;
  value_t mul_b_mcand;
  value_t mul_b_mplier;
  logic   mul_a_busy;
  logic   mul_b_busy;
  wide_t  mul_a_prod;
  wide_t  mul_b_prod;
  logic   mul_idle;

  logic [WIDE_WIDTH:0] p_new;
  logic [WIDE_WIDTH:0] q_new;
  logic                over;
  value_t              t_min;
  value_t              half;
  logic                pick_take;
  logic                pick_tie;
  logic                cmp_take;

  assign in_ready = (state == S_IDLE);
  assign mul_idle = !mul_a_busy && !mul_b_busy;

  always_comb begin
    p_new     = {{(VALUE_WIDTH + 1){1'b0}}, p_old} + {1'b0, mul_a_prod};
    q_new     = {{(VALUE_WIDTH + 1){1'b0}}, q_old} + {1'b0, mul_b_prod};
    over      = (p_new > {{(VALUE_WIDTH + 1){1'b0}}, num_limit}) ||
                (q_new > {{(VALUE_WIDTH + 1){1'b0}}, den_limit});
    t_min     = (room_n < room_d) ? room_n : room_d;
    half      = term >> 1;
    pick_take = (t_min > half);
    pick_tie  = !term[0] && (t_min == half);
    cmp_take  = (mul_a_prod > mul_b_prod);
  end

  // divider operand select and start
  always_comb begin
    div_start    = 1'b0;
    div_dividend = num;
    div_divisor  = den;
    case (state)
      S_CHECK: begin
        div_start = (den != '0);
      end
      S_RN: begin
        div_dividend = num_limit - p_old;
        div_divisor  = p_cur;
        div_start    = (p_cur != '0) && (num_limit >= p_old);
      end
      S_RD: begin
        div_dividend = den_limit - q_old;
        div_divisor  = q_cur;
        div_start    = (q_cur != '0) && (den_limit >= q_old);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // multiplier operand select and start
  always_comb begin
    mul_start    = 1'b0;
    mul_a_mcand  = p_cur;
    mul_a_mplier = t_min;
    mul_b_mcand  = q_cur;
    mul_b_mplier = t_min;
    case (state)
      S_DIV: begin
        mul_a_mplier = div_quotient;
        mul_b_mplier = div_quotient;
        mul_start    = !div_busy;
      end
      S_PICK: begin
        if (!pick_take) begin
          // tie break: q_old * prev_den against q_cur * new remainder
          mul_a_mcand  = den;
          mul_a_mplier = q_old;
          mul_b_mcand  = rem;
          mul_b_mplier = q_cur;
        end
        mul_start = pick_take || pick_tie;
      end
      S_CMP: begin
        mul_start = mul_idle && cmp_take;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  bra_serial_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  bra_serial_mul u_mul_a (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (mul_a_mcand),
    .multiplier   (mul_a_mplier),
    .busy         (mul_a_busy),
    .product      (mul_a_prod)
  );

  bra_serial_mul u_mul_b (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (mul_b_mcand),
    .multiplier   (mul_b_mplier),
    .busy         (mul_b_busy),
    .product      (mul_b_prod)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_limit <= NUM_LIMIT_RESET;
      den_limit <= DEN_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NUM_LIMIT: num_limit <= cfg_data;
        REG_DEN_LIMIT: den_limit <= cfg_data;
        default: begin
          num_limit <= num_limit;
        end
      endcase
    end
  end

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // in S_EMIT the output register is reloaded below instead
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            num   <= frac_numerator;
            den   <= frac_denominator;
            p_old <= '0;
            q_old <= value_t'(1);
            p_cur <= value_t'(1);
            q_cur <= '0;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (den == '0) ? S_EMIT : S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            term  <= div_quotient;
            rem   <= div_remainder;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_idle) begin
            if (over) begin
              state <= S_RN;
            end else begin
              p_old <= p_cur;
              p_cur <= p_new[VALUE_WIDTH-1:0];
              q_old <= q_cur;
              q_cur <= q_new[VALUE_WIDTH-1:0];
              num   <= den;
              den   <= rem;
              state <= S_CHECK;
            end
          end
        end
        S_RN: begin
          if (p_cur == '0) begin
            room_n <= '1;
            state  <= S_RD;
          end else if (num_limit < p_old) begin
            room_n <= '0;
            state  <= S_RD;
          end else begin
            state <= S_RN_WAIT;
          end
        end
        S_RN_WAIT: begin
          if (!div_busy) begin
            room_n <= div_quotient;
            state  <= S_RD;
          end
        end
        S_RD: begin
          if (q_cur == '0) begin
            room_d <= '1;
            state  <= S_PICK;
          end else if (den_limit < q_old) begin
            room_d <= '0;
            state  <= S_PICK;
          end else begin
            state <= S_RD_WAIT;
          end
        end
        S_RD_WAIT: begin
          if (!div_busy) begin
            room_d <= div_quotient;
            state  <= S_PICK;
          end
        end
        S_PICK: begin
          if (pick_take) begin
            state <= S_SEMI;
          end else if (pick_tie) begin
            state <= S_CMP;
          end else begin
            state <= S_EMIT;
          end
        end
        S_CMP: begin
          if (mul_idle) begin
            state <= cmp_take ? S_SEMI : S_EMIT;
          end
        end
        S_SEMI: begin
          if (mul_idle) begin
            p_cur <= p_old + mul_a_prod[VALUE_WIDTH-1:0];
            q_cur <= q_old + mul_b_prod[VALUE_WIDTH-1:0];
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            approx_numerator   <= p_cur;
            approx_denominator <= q_cur;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/bra_serial_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, stops early once remaining bits are zero.
module bra_serial_mul
  import bra_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  value_t multiplicand,
  input  value_t multiplier,
  output logic   busy,
  output wide_t  product
);

  wide_t  mcand_sh;
  value_t mplier_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy      <= 1'b1;
      product   <= '0;
      mcand_sh  <= {{VALUE_WIDTH{1'b0}}, multiplicand};
      mplier_sh <= multiplier;
    end else if (busy) begin
      if (mplier_sh == '0) begin
        busy <= 1'b0;
      end else begin
        if (mplier_sh[0]) begin
          product <= product + mcand_sh;
        end
        mcand_sh  <= mcand_sh << 1;
        mplier_sh <= mplier_sh >> 1;
      end
    end
  end

endmodule

@@ rtl/bra_serial_div.sv @@
// Restoring divider, one quotient bit per cycle; divisor must be nonzero.
module bra_serial_div
  import bra_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  value_t dividend,
  input  value_t divisor,
  output logic   busy,
  output value_t quotient,
  output value_t remainder
);

  localparam count_t LAST = count_t'(VALUE_WIDTH - 1);

  count_t                 count;
  value_t                 divisor_hold;
  logic [VALUE_WIDTH:0]   partial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;
  value_t                 rem_next;

  // divisor is captured at start; the caller may move its operand select afterwards
  always_comb begin
    partial  = {remainder, quotient[VALUE_WIDTH-1]};
    diff     = partial - {1'b0, divisor_hold};
    fits     = (partial >= {1'b0, divisor_hold});
    rem_next = fits ? diff[VALUE_WIDTH-1:0] : partial[VALUE_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy         <= 1'b1;
      count        <= '0;
      remainder    <= '0;
      quotient     <= dividend;
      divisor_hold <= divisor;
    end else if (busy) begin
      remainder <= rem_next;
      quotient  <= {quotient[VALUE_WIDTH-2:0], fits};
      count     <= count + count_t'(1);
      if (count == LAST) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
